// ===== rtl/drpt_pkg.sv =====
// shared types and constants for the dma ring position tracker
package drpt_pkg;

   // action codes carried in a request word
   localparam logic [1:0] ACT_START     = 2'd0;
   localparam logic [1:0] ACT_INTERRUPT = 2'd1;
   localparam logic [1:0] ACT_QUERY     = 2'd2;
   localparam logic [1:0] ACT_STOP      = 2'd3;

   // highest descriptor index of the ring, also the last-valid reset value
   localparam logic [4:0] RING_LAST = 5'd31;

   typedef struct packed {
      logic [1:0]  action;
      logic        interrupt_pending;
      logic        fifo_error;
      logic        engine_halted;
      logic        last_entry_done;
      logic [4:0]  current_index;
      logic [4:0]  current_index_again;
      logic [15:0] remaining_samples;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  completed_periods;
      logic [63:0] play_position;
      logic [4:0]  last_valid_index;
      logic        write_last_index;
      logic        error_flag;
      logic        is_running;
   } rsp_word_type;

   // outcome of one position sample
   typedef struct packed {
      logic [63:0] position;
      logic        clear_terminal;
   } sample_type;

endpackage

// ===== rtl/drpt_sample.sv =====
// position sample: consistency check, terminal-entry guard and monotonic raise
module drpt_sample #(
   parameter int PERIOD_SAMPLES = 2048
) (
   input  logic                  running,
   input  logic                  terminal_pending,
   input  logic [4:0]            next_done_index,
   input  logic [63:0]           done_frames,
   input  logic [63:0]           reported_position,
   input  logic [4:0]            current_index,
   input  logic [4:0]            current_index_again,
   input  logic [15:0]           remaining_samples,
   output drpt_pkg::sample_type  sample
);

   localparam logic [16:0] PERIOD_W = 17'(PERIOD_SAMPLES);
   localparam logic [14:0] FRAMES_W = 15'(PERIOD_SAMPLES / 2);

   logic        consistent;
   logic        terminal_hit;
   logic [4:0]  distance;
   logic [15:0] partial;
   logic [19:0] span;
   logic [63:0] candidate;
   logic [63:0] base;

   always_comb begin
      consistent   = (current_index == current_index_again) &&
                     ({1'b0, remaining_samples} <= PERIOD_W);
      terminal_hit = terminal_pending && (current_index == next_done_index - 5'd1);
      distance     = current_index - next_done_index;
      partial      = 16'((PERIOD_W - {1'b0, remaining_samples}) >> 1);
      span         = {15'd0, distance} * {5'd0, FRAMES_W};
      candidate    = done_frames + {44'd0, span} + {48'd0, partial};
      base         = terminal_hit ? done_frames : candidate;

      sample.clear_terminal = running && consistent && !terminal_hit;
      if (running && consistent && (base > reported_position)) begin
         sample.position = base;
      end else begin
         sample.position = reported_position;
      end
   end

endmodule

// ===== rtl/dma_ring_position_tracker.sv =====
// top level of the dma ring position tracker
//
// tracks playback progress through a 32-entry audio descriptor ring.
// req channel: one word per driver event (start, interrupt, position query,
// stop) with the sampled status flags, two index samples and the remaining
// sample count. rsp channel: exactly one word per request word, carrying the
// completed period count, the monotonic play position in frames, the last
// valid index to program and the error and running flags.
// a request taken into the input register passes through the state update
// into the response register, where it waits until the receiver takes it.
// throughput: one word per cycle while rsp_stall is low; the state
// update is a single pass of logic between the input register and the
// response register, so consecutive words never wait on each other.
// when rsp_stall is high the response register holds its word; the input
// register still takes one more word, after which req_stall rises until the
// response is taken.
// reset (synchronous, active high) empties both registers, stops the block
// and sets the last valid index to 31 with all counters cleared.
module dma_ring_position_tracker #(
   parameter int PERIOD_SAMPLES = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  drpt_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output drpt_pkg::rsp_word_type rsp_word
);

   localparam logic [14:0] FRAMES_W = 15'(PERIOD_SAMPLES / 2);

   // input register
   logic                   in_valid_ff;
   drpt_pkg::req_word_type in_word_ff;

   // tracker state
   logic        running_ff, running_in;
   logic [4:0]  next_done_ff, next_done_in;
   logic [4:0]  last_valid_ff, last_valid_in;
   logic [63:0] done_frames_ff, done_frames_in;
   logic [63:0] position_ff, position_in;
   logic        terminal_ff, terminal_in;

   // response register
   logic                   rsp_valid_ff;
   drpt_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                 advance;
   logic                 take_req;
   logic [5:0]           completed;
   logic [20:0]          frames_added;
   logic                 terminal;
   drpt_pkg::sample_type sample;

   // input register holds a word and the response slot is free or being emptied this cycle
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // input register is blocked only while it holds a word that cannot move on
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   drpt_sample #(
      .PERIOD_SAMPLES(PERIOD_SAMPLES)
   ) u_sample (
      .running             (running_ff),
      .terminal_pending    (terminal_ff),
      .next_done_index     (next_done_ff),
      .done_frames         (done_frames_ff),
      .reported_position   (position_ff),
      .current_index       (in_word_ff.current_index),
      .current_index_again (in_word_ff.current_index_again),
      .remaining_samples   (in_word_ff.remaining_samples),
      .sample              (sample)
   );

   always_comb begin
      // periods finished since the last interrupt, one more when the engine
      // halted on the terminal entry
      terminal     = in_word_ff.engine_halted && in_word_ff.last_entry_done;
      completed    = {1'b0, in_word_ff.current_index - next_done_ff} + {5'd0, terminal};
      frames_added = {15'd0, completed} * {6'd0, FRAMES_W};

      running_in     = running_ff;
      next_done_in   = next_done_ff;
      last_valid_in  = last_valid_ff;
      done_frames_in = done_frames_ff;
      position_in    = position_ff;
      terminal_in    = terminal_ff;

      rsp_word_in.completed_periods = 6'd0;
      rsp_word_in.write_last_index  = 1'b0;
      rsp_word_in.error_flag        = 1'b0;

      case (in_word_ff.action)
         drpt_pkg::ACT_START: begin
            if (running_ff) begin
               // refused start, nothing changes
               rsp_word_in.error_flag = 1'b1;
            end else begin
               running_in     = 1'b1;
               next_done_in   = 5'd0;
               last_valid_in  = drpt_pkg::RING_LAST;
               done_frames_in = 64'd0;
               position_in    = 64'd0;
               terminal_in    = 1'b0;
               rsp_word_in.write_last_index = 1'b1;
            end
         end
         drpt_pkg::ACT_INTERRUPT: begin
            if (running_ff && in_word_ff.interrupt_pending) begin
               if (in_word_ff.fifo_error) begin
                  // fifo error: last position sample, then stop
                  position_in = sample.position;
                  if (sample.clear_terminal) begin
                     terminal_in = 1'b0;
                  end
                  running_in = 1'b0;
                  rsp_word_in.error_flag = 1'b1;
               end else begin
                  done_frames_in = done_frames_ff + {43'd0, frames_added};
                  next_done_in   = next_done_ff + completed[4:0];
                  last_valid_in  = last_valid_ff + completed[4:0];
                  rsp_word_in.completed_periods = completed;
                  if (completed != 6'd0) begin
                     terminal_in = terminal;
                     rsp_word_in.write_last_index = 1'b1;
                  end
               end
            end
         end
         drpt_pkg::ACT_QUERY: begin
            position_in = sample.position;
            if (sample.clear_terminal) begin
               terminal_in = 1'b0;
            end
         end
         drpt_pkg::ACT_STOP: begin
            position_in = sample.position;
            if (sample.clear_terminal) begin
               terminal_in = 1'b0;
            end
            running_in = 1'b0;
         end
         default: begin
            running_in = running_ff;
         end
      endcase

      rsp_word_in.play_position    = position_in;
      rsp_word_in.last_valid_index = last_valid_in;
      rsp_word_in.is_running       = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         running_ff     <= 1'b0;
         next_done_ff   <= 5'd0;
         last_valid_ff  <= drpt_pkg::RING_LAST;
         done_frames_ff <= 64'd0;
         position_ff    <= 64'd0;
         terminal_ff    <= 1'b0;
      end else begin
         // input register refills whenever it is not held
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            running_ff     <= running_in;
            next_done_ff   <= next_done_in;
            last_valid_ff  <= last_valid_in;
            done_frames_ff <= done_frames_in;
            position_ff    <= position_in;
            terminal_ff    <= terminal_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// ===== rtl/drpt_checker.sv =====
// port-level checker for the dma ring position tracker, with its bind
module drpt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input drpt_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input drpt_pkg::rsp_word_type rsp_word
);

   // both sides come out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response valid or request stall after reset");

   // a stalled response word is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed or dropped");

   // an accepted request always yields a valid response on the port
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("accepted request produced no response");

   // counted periods always come with a last-index write and keep running
   a_periods_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.completed_periods != 6'd0) |->
         rsp_word.write_last_index && rsp_word.is_running && !rsp_word.error_flag)
      else $error("completed periods without last index write");

endmodule

bind dma_ring_position_tracker drpt_checker u_drpt_checker (.*);
